// ===== rtl/tmp_pkg.sv =====
// Package for the trapezoidal motion profile block: widths, register indexes, codes.
// No dependencies.
`default_nettype none
package tmp_pkg;
	localparam int PosW = 32;
	localparam int SpdW = 31;
	localparam int DtW = 16;
	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_SPEED_LIMIT = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_ACCEL_LIMIT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_POS_MIN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_POS_MAX = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_POS_EN = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_SPD_EN = 3'd5;
	localparam logic [CfgIdxW-1:0] REG_ACC_EN = 3'd6;
	localparam int MulW = 64;
	localparam int MulCntW = 6;

	typedef struct packed {
		logic start;
		logic [SpdW-1:0] a;
		logic [32:0] b;
		logic [MulCntW-1:0] nbits;
	} tmp_mul_req_t;
endpackage
`default_nettype wire

// ===== rtl/tmp_serial_mul.sv =====
// Bit-serial shift-and-add multiplier: one multiplier bit per cycle.
// Depends on tmp_pkg.
`default_nettype none
module tmp_serial_mul import tmp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire tmp_mul_req_t req,
	output logic done,
	output logic [MulW-1:0] prod
);
	logic [MulW-1:0] acc_q, mcand_q;
	logic [32:0] mplier_q;
	logic [MulCntW-1:0] cnt_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - MulCntW'(1);
				if (cnt_q == MulCntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			mcand_q <= {{(MulW-SpdW){1'b0}}, req.a};
			mplier_q <= req.b;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q <= {mcand_q[MulW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[32:1]};
		end
	end

	assign prod = acc_q;
endmodule
`default_nettype wire

// ===== rtl/tmp_core.sv =====
// Sequencer for one target or tick item; shares the serial multiplier.
// Depends on tmp_pkg and tmp_serial_mul.
`default_nettype none
module tmp_core import tmp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_go,
	input  wire logic in_cmd,
	input  wire logic [PosW-1:0] in_tpos,
	input  wire logic [PosW-1:0] in_tspd,
	input  wire logic [PosW-1:0] in_tacc,
	input  wire logic [DtW-1:0] in_dt,
	input  wire logic [SpdW-1:0] speed_limit,
	input  wire logic [SpdW-1:0] accel_limit,
	input  wire logic signed [PosW-1:0] pos_min,
	input  wire logic signed [PosW-1:0] pos_max,
	input  wire logic pos_en,
	input  wire logic spd_en,
	input  wire logic acc_en,
	output logic busy,
	output logic res_valid,
	output logic signed [PosW-1:0] res_pos,
	output logic [SpdW-1:0] res_spd,
	output logic signed [PosW-1:0] res_acc
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LHS = 3'd1;
	localparam logic [2:0] ST_RHS = 3'd2;
	localparam logic [2:0] ST_DV = 3'd3;
	localparam logic [2:0] ST_STEP = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q;
	logic signed [PosW-1:0] cur_pos_q, goal_pos_q, cur_acc_q;
	logic [SpdW-1:0] cur_spd_q, goal_spd_q, goal_acc_q;
	logic [DtW-1:0] dt_q;
	logic [32:0] dist_q;
	logic [MulW-1:0] lhs_q, rhs_q;
	logic err_pos_q;
	logic issue_q;
	tmp_mul_req_t mreq;
	logic mdone;
	logic [MulW-1:0] mprod;

	tmp_serial_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .prod(mprod));

	function automatic logic [SpdW-1:0] mag31(input logic [PosW-1:0] v);
		logic [PosW-1:0] n;
		n = v[PosW-1] ? (~v + 32'd1) : v;
		return (v == 32'h8000_0000) ? {SpdW{1'b1}} : n[SpdW-1:0];
	endfunction

	function automatic logic signed [PosW-1:0] clampp(input logic signed [PosW-1:0] p,
		input logic en, input logic signed [PosW-1:0] lo, input logic signed [PosW-1:0] hi);
		logic signed [PosW-1:0] r;
		r = p;
		if (en) begin
			if (p > hi) r = hi;
			else if (p < lo) r = lo;
		end
		return r;
	endfunction

	logic signed [32:0] err;
	logic [SpdW-1:0] tspd_m, tacc_m, dv, spd_new;
	logic [31:0] vsum;
	logic signed [33:0] pnew;
	logic signed [PosW-1:0] psat;
	logic accel_up, accel_dn;
	assign err = {goal_pos_q[PosW-1], goal_pos_q} - {cur_pos_q[PosW-1], cur_pos_q};
	assign tspd_m = mag31(in_tspd);
	assign tacc_m = mag31(in_tacc);
	assign dv = mprod[SpdW+15:16];
	assign vsum = {1'b0, cur_spd_q} + {1'b0, dv};
	assign accel_up = lhs_q > rhs_q;
	assign accel_dn = lhs_q < rhs_q;
	always_comb begin
		spd_new = cur_spd_q;
		if (accel_up) begin
			if (cur_spd_q < goal_spd_q)
				spd_new = (vsum > {1'b0, goal_spd_q}) ? goal_spd_q : vsum[SpdW-1:0];
			else
				spd_new = goal_spd_q;
		end else if (accel_dn) begin
			spd_new = (cur_spd_q > dv) ? cur_spd_q - dv : '0;
		end
	end
	assign pnew = err_pos_q ? ({{2{cur_pos_q[PosW-1]}}, cur_pos_q} + {3'b0, mprod[SpdW+15:16]})
		: ({{2{cur_pos_q[PosW-1]}}, cur_pos_q} - {3'b0, mprod[SpdW+15:16]});
	assign psat = (pnew > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
		(pnew < -34'sh0_8000_0000) ? 32'sh8000_0000 : pnew[PosW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			issue_q <= 1'b0;
			res_valid <= 1'b0;
			cur_pos_q <= '0; goal_pos_q <= '0; cur_acc_q <= '0;
			cur_spd_q <= '0; goal_spd_q <= '0; goal_acc_q <= '0;
			dt_q <= '0; dist_q <= '0; lhs_q <= '0; rhs_q <= '0; err_pos_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			issue_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_go) begin
					if (in_cmd) begin
						goal_pos_q <= clampp(in_tpos, pos_en, pos_min, pos_max);
						goal_spd_q <= (spd_en && tspd_m > speed_limit) ? speed_limit : tspd_m;
						goal_acc_q <= (acc_en && tacc_m > accel_limit) ? accel_limit : tacc_m;
					end else begin
						dt_q <= in_dt;
						state_q <= ST_LHS;
					end
				end
				ST_LHS: begin
					if (err == '0) begin
						cur_spd_q <= '0;
						cur_acc_q <= '0;
						res_valid <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						if (goal_spd_q == '0) goal_spd_q <= speed_limit;
						if (goal_acc_q == '0) goal_acc_q <= accel_limit;
						dist_q <= err[32] ? -err : err;
						err_pos_q <= !err[32];
						issue_q <= 1'b1;
						state_q <= ST_RHS;
					end
				end
				ST_RHS: if (mdone) begin
					lhs_q <= mprod;
					issue_q <= 1'b1;
					state_q <= ST_DV;
				end
				ST_DV: if (mdone) begin
					rhs_q <= mprod;
					issue_q <= 1'b1;
					state_q <= ST_STEP;
				end
				ST_STEP: if (mdone) begin
					cur_spd_q <= spd_new;
					if (accel_up) cur_acc_q <= {1'b0, goal_acc_q};
					else if (accel_dn) cur_acc_q <= -{1'b0, goal_acc_q};
					issue_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: if (mdone) begin
					cur_pos_q <= clampp(psat, pos_en, pos_min, pos_max);
					res_valid <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_RHS: begin
				mreq.start = issue_q;
				mreq.a = goal_acc_q;
				mreq.b = dist_q;
				mreq.nbits = MulCntW'(33);
			end
			ST_DV: begin
				mreq.start = issue_q;
				mreq.a = cur_spd_q;
				mreq.b = {2'b0, cur_spd_q};
				mreq.nbits = MulCntW'(31);
			end
			ST_STEP: begin
				mreq.start = issue_q;
				mreq.a = goal_acc_q;
				mreq.b = {17'b0, dt_q};
				mreq.nbits = MulCntW'(16);
			end
			ST_DONE: begin
				mreq.start = issue_q;
				mreq.a = cur_spd_q;
				mreq.b = {17'b0, dt_q};
				mreq.nbits = MulCntW'(16);
			end
			default: begin end
		endcase
	end

	assign busy = (state_q != ST_IDLE) || res_valid;
	assign res_pos = cur_pos_q;
	assign res_spd = cur_spd_q;
	assign res_acc = cur_acc_q;
endmodule
`default_nettype wire

// ===== rtl/trapezoidal_motion_profile_top.sv =====
// Top level of the trapezoidal motion profile: stream ports, register file, output register.
// Depends on tmp_pkg and tmp_core.
// A target beat is taken and the next beat may follow at once. A tick beat with the position
// off target has its error formed first, then four products (33, 31, 16 and 16 bits) in one
// shared shift-and-add multiplier, one after another, before its result shows on m_tvalid.
// A tick at the target shows its result without the products. One item is worked at a time;
// the input stalls while a tick is worked and while a result waits in the output register,
// and with m_tready high the next beat can be taken in the same cycle as the result appears.
`default_nettype none
module trapezoidal_motion_profile_top import tmp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [111:0] s_tdata, // target_position, target_speed, target_accel, dt
	input  wire logic s_tuser,         // cmd
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [95:0] m_tdata,       // position, speed, accel, zero pad
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [SpdW-1:0] speed_limit_q, accel_limit_q;
	logic signed [PosW-1:0] pos_min_q, pos_max_q;
	logic pos_en_q, spd_en_q, acc_en_q;
	logic busy, res_valid;
	logic signed [PosW-1:0] res_pos, res_acc;
	logic [SpdW-1:0] res_spd;
	logic go;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q <= 31'd65536; accel_limit_q <= 31'd65536;
			pos_min_q <= 32'sh8000_0000; pos_max_q <= 32'sh7FFF_FFFF;
			pos_en_q <= 1'b0; spd_en_q <= 1'b0; acc_en_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SPEED_LIMIT: speed_limit_q <= cfg_data[SpdW-1:0];
				REG_ACCEL_LIMIT: accel_limit_q <= cfg_data[SpdW-1:0];
				REG_POS_MIN: pos_min_q <= cfg_data;
				REG_POS_MAX: pos_max_q <= cfg_data;
				REG_POS_EN: pos_en_q <= cfg_data[0];
				REG_SPD_EN: spd_en_q <= cfg_data[0];
				REG_ACC_EN: acc_en_q <= cfg_data[0];
				default: begin end
			endcase
		end
	end

	assign s_tready = !busy && !(m_tvalid && !m_tready);
	assign go = s_tvalid && s_tready;

	tmp_core u_core (.clk(clk), .arst_n(arst_n), .in_go(go), .in_cmd(s_tuser),
		.in_tpos(s_tdata[31:0]), .in_tspd(s_tdata[63:32]), .in_tacc(s_tdata[95:64]),
		.in_dt(s_tdata[111:96]), .speed_limit(speed_limit_q), .accel_limit(accel_limit_q),
		.pos_min(pos_min_q), .pos_max(pos_max_q), .pos_en(pos_en_q), .spd_en(spd_en_q),
		.acc_en(acc_en_q), .busy(busy), .res_valid(res_valid), .res_pos(res_pos),
		.res_spd(res_spd), .res_acc(res_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (res_valid) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_valid) m_tdata <= {1'b0, res_acc, res_spd, res_pos};
	end
endmodule
`default_nettype wire

// ===== rtl/tmp_checker.sv =====
// Port checker for the motion profile top level, bound to it.
// Depends on trapezoidal_motion_profile_top ports only.
`default_nettype none
module tmp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [95:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("input taken over stalled beat");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[95]) else $error("pad bit set");
endmodule
bind trapezoidal_motion_profile_top tmp_checker u_chk (.clk(clk), .arst_n(arst_n),
	.s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata));
`default_nettype wire
